// ===== hdl/crc_checked_angle_from_xy_macros.svh =====
// ----------------------------------------------------------------------------
// crc_checked_angle_from_xy_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_ANGLE_FROM_XY_MACROS_SVH
`define CRC_CHECKED_ANGLE_FROM_XY_MACROS_SVH

// check the consequent in the same cycle
`define CCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cca assertion failed");

// check the consequent in the next cycle
`define CCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cca assertion failed");

`endif

// ===== hdl/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg
// Types, constants and helper functions of the CRC checked angle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cca_pkg;

  localparam int XY_W     = 43;
  localparam int IN_SCALE = 24;
  localparam int Z_W      = 26;
  localparam int ACC_FRAC = 16;
  localparam int TAB_LEN  = 24;

  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFB;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_CRC   = 2'd1;
  localparam logic [1:0] STAT_VALUE = 2'd2;

  localparam logic signed [Z_W-1:0] DEG180 = 26'sd11796480;

  typedef struct packed {
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic        [7:0]  frame_crc;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [15:0] angle_deg;
  } out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic        [31:0]     raw;
    logic        [7:0]      crc;
    logic        [7:0]      rx;
    logic                   bad;
  } stage_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] t;
    case (idx)
      5'd0:    t = 26'sd2949120;
      5'd1:    t = 26'sd1740967;
      5'd2:    t = 26'sd919879;
      5'd3:    t = 26'sd466945;
      5'd4:    t = 26'sd234379;
      5'd5:    t = 26'sd117304;
      5'd6:    t = 26'sd58666;
      5'd7:    t = 26'sd29335;
      5'd8:    t = 26'sd14668;
      5'd9:    t = 26'sd7334;
      5'd10:   t = 26'sd3667;
      5'd11:   t = 26'sd1833;
      5'd12:   t = 26'sd917;
      5'd13:   t = 26'sd458;
      5'd14:   t = 26'sd229;
      5'd15:   t = 26'sd115;
      5'd16:   t = 26'sd57;
      5'd17:   t = 26'sd29;
      5'd18:   t = 26'sd14;
      5'd19:   t = 26'sd7;
      5'd20:   t = 26'sd4;
      5'd21:   t = 26'sd2;
      5'd22:   t = 26'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/cca_stage.sv =====
// ----------------------------------------------------------------------------
// cca_stage
// One registered CORDIC vectoring iteration; the first four also fold one
// frame byte into the CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cca_stage #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cca_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cca_pkg::stage_t out_data
);

  localparam int         ByteSel = (IDX < 4) ? IDX : 0;
  localparam logic [4:0] TabIdx  = 5'(IDX);

  logic                               valid_r;
  cca_pkg::stage_t                    data_r;
  cca_pkg::stage_t                    data_nxt;
  logic signed [cca_pkg::XY_W-1:0]    xs;
  logic signed [cca_pkg::XY_W-1:0]    ys;
  logic signed [cca_pkg::Z_W-1:0]     tab;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt = in_data;
    xs       = in_data.x >>> IDX;
    ys       = in_data.y >>> IDX;
    tab      = cca_pkg::atan_entry(TabIdx);
    if (!in_data.y[cca_pkg::XY_W-1]) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + tab;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - tab;
    end
    if (IDX < 4) begin
      data_nxt.crc = cca_pkg::crc_byte(in_data.crc, in_data.raw[8*ByteSel +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/crc_checked_angle_from_xy.sv =====
// Throughput: one request per cycle unless out_ready stalls the pipeline; one
// input register, one register per CORDIC iteration and one output register,
// each with its own valid bit.
// Reset: synchronous, active low; clears all valid bits, data is not reset.
// ----------------------------------------------------------------------------
// crc_checked_angle_from_xy
// CRC-8 checked sensor frame to atan2 angle in degrees, pipelined CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_angle_from_xy #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  cca_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output cca_pkg::out_t out_data
);

  localparam int NStg  = (CORDIC_STAGES > cca_pkg::TAB_LEN) ? cca_pkg::TAB_LEN : CORDIC_STAGES;
  localparam int RndSh = cca_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int PadW  = cca_pkg::XY_W - 17 - cca_pkg::IN_SCALE;

  localparam logic signed [cca_pkg::Z_W-1:0] RndHalf = cca_pkg::Z_W'(1 << (RndSh - 1));
  localparam logic signed [cca_pkg::Z_W-1:0] SatHi   = cca_pkg::Z_W'(32767);
  localparam logic signed [cca_pkg::Z_W-1:0] SatLo   = cca_pkg::Z_W'(-32768);

  function automatic logic bad_value(input logic signed [15:0] v);
    return (v == 16'sh0000) || (v == 16'sh7FFF) || (v == 16'sh8000);
  endfunction

  logic                 pre_valid_r;
  cca_pkg::stage_t      pre_data_r;
  cca_pkg::stage_t      pre_nxt;
  logic signed [16:0]   xe;
  logic signed [16:0]   ye;

  cca_pkg::stage_t      lnk_data  [0:NStg];
  logic                 lnk_valid [0:NStg];
  logic                 lnk_ready [0:NStg];

  logic                 out_valid_r;
  cca_pkg::out_t        out_data_r;
  cca_pkg::out_t        out_nxt;
  logic                 out_take;
  cca_pkg::stage_t      fin;
  logic signed [cca_pkg::Z_W-1:0] rnd;

  // input register: pre-rotate into the right half plane and scale
  assign in_ready = !pre_valid_r || lnk_ready[0];

  always_comb begin
    xe = $signed({in_data.x_raw[15], in_data.x_raw});
    ye = $signed({in_data.y_raw[15], in_data.y_raw});
    pre_nxt.z = '0;
    if (in_data.x_raw[15]) begin
      xe = -xe;
      ye = -ye;
      pre_nxt.z = in_data.y_raw[15] ? -cca_pkg::DEG180 : cca_pkg::DEG180;
    end
    pre_nxt.x   = {{PadW{xe[16]}}, xe, {cca_pkg::IN_SCALE{1'b0}}};
    pre_nxt.y   = {{PadW{ye[16]}}, ye, {cca_pkg::IN_SCALE{1'b0}}};
    pre_nxt.raw = {in_data.y_raw, in_data.x_raw};
    pre_nxt.crc = cca_pkg::CRC_INIT;
    pre_nxt.rx  = in_data.frame_crc;
    pre_nxt.bad = bad_value(in_data.x_raw) || bad_value(in_data.y_raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (in_ready) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pre_data_r <= pre_nxt;
    end
  end

  assign lnk_data[0]  = pre_data_r;
  assign lnk_valid[0] = pre_valid_r;

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    cca_stage #(
      .IDX(g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (lnk_valid[g]),
      .in_ready (lnk_ready[g]),
      .in_data  (lnk_data[g]),
      .out_valid(lnk_valid[g+1]),
      .out_ready(lnk_ready[g+1]),
      .out_data (lnk_data[g+1])
    );
  end

  // output register: CRC compare, value check, round and saturate
  assign out_take        = !out_valid_r || out_ready;
  assign lnk_ready[NStg] = out_take;
  assign fin             = lnk_data[NStg];

  always_comb begin
    rnd = (fin.z + RndHalf) >>> RndSh;
    out_nxt.status    = cca_pkg::STAT_OK;
    out_nxt.angle_deg = '0;
    if ((~fin.crc) != fin.rx) begin
      out_nxt.status = cca_pkg::STAT_CRC;
    end else if (fin.bad) begin
      out_nxt.status = cca_pkg::STAT_VALUE;
    end else if (rnd > SatHi) begin
      out_nxt.angle_deg = 16'sh7FFF;
    end else if (rnd < SatLo) begin
      out_nxt.angle_deg = 16'sh8000;
    end else begin
      out_nxt.angle_deg = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= lnk_valid[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && lnk_valid[NStg]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/cca_checker.sv =====
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks of the CRC checked angle block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc_checked_angle_from_xy_macros.svh"

module cca_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input cca_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input cca_pkg::out_t out_data
);

  logic failed;

  assign failed = (out_data.status != cca_pkg::STAT_OK);

  `CCA_ASSERT_SAME(a_fail_zero, out_valid && failed, out_data.angle_deg == '0)
  `CCA_ASSERT_SAME(a_no_stall_full_rate, out_ready, in_ready)
  `CCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `CCA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

endmodule

bind crc_checked_angle_from_xy cca_checker u_cca_checker (.*);

// ===== test/tb_crc_checked_angle_from_xy.sv =====
// ----------------------------------------------------------------------------
// tb_crc_checked_angle_from_xy
// Drives sensor frames into the CRC checked angle block and compares each
// result with a bit-exact CRC-8 and CORDIC prediction kept in a scoreboard.
// Covers directed corner frames, then random frames under several idle and
// stall mixes, including a long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_crc_checked_angle_from_xy;

  localparam int     STAGES         = 16;
  localparam int     FRAC_BITS      = 7;
  localparam int     ATAN_LEN       = 24;
  localparam int     ACC_BITS       = 16;
  localparam int     ROUND_SHIFT    = ACC_BITS - FRAC_BITS;
  localparam int     INPUT_SHIFT    = 24;
  localparam longint HALF_TURN_Q16  = 64'sd11796480;
  localparam int     LATENCY        = STAGES + 2;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     PHASE_FRAMES   = 256;

  class angle_checker;
    cca_pkg::out_t awaited_results[$];
    longint        atan_q16[ATAN_LEN];
    int            mismatches;
    int            requests_seen;
    int            results_seen;
    int            status_seen[3];

    function new();
      atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
      mismatches    = 0;
      requests_seen = 0;
      results_seen  = 0;
      status_seen   = '{0, 0, 0};
    endfunction

    static function logic [7:0] sensor_crc(logic [15:0] x, logic [15:0] y);
      logic [31:0] msg;
      logic [7:0]  c;
      logic        fb;
      msg = {x[7:0], x[15:8], y[7:0], y[15:8]};
      c   = cca_pkg::CRC_INIT;
      for (int i = 31; i >= 0; i--) begin
        fb = c[7] ^ msg[i];
        c  = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ cca_pkg::CRC_POLY;
        end
      end
      return ~c;
    endfunction

    static function bit zero_or_railed(logic signed [15:0] v);
      return (v == 16'sd0) || (v == 16'sd32767) || (v == -16'sd32768);
    endfunction

    function logic signed [15:0] cordic_angle(logic signed [15:0] y_in,
                                              logic signed [15:0] x_in);
      longint x, y, z, xs, ys, r;
      x = x_in;
      y = y_in;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
        x = -x;
        y = -y;
      end
      x = x * (longint'(1) <<< INPUT_SHIFT);
      y = y * (longint'(1) <<< INPUT_SHIFT);
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_q16[i];
        end
      end
      r = z;
      if (ROUND_SHIFT > 0) begin
        r = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      end
      if (r > 32767) begin
        r = 32767;
      end
      if (r < -32768) begin
        r = -32768;
      end
      return 16'(r);
    endfunction

    function cca_pkg::out_t predict_angle_result(cca_pkg::in_t req);
      cca_pkg::out_t res;
      res.angle_deg = '0;
      if (req.frame_crc != sensor_crc(req.x_raw, req.y_raw)) begin
        res.status = cca_pkg::STAT_CRC;
      end else if (zero_or_railed(req.x_raw) || zero_or_railed(req.y_raw)) begin
        res.status = cca_pkg::STAT_VALUE;
      end else begin
        res.status    = cca_pkg::STAT_OK;
        res.angle_deg = cordic_angle(req.y_raw, req.x_raw);
      end
      return res;
    endfunction

    function void note_request(cca_pkg::in_t req);
      awaited_results.push_back(predict_angle_result(req));
      requests_seen++;
    endfunction

    function void check_result(cca_pkg::out_t got);
      cca_pkg::out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d angle %0d",
                 $time, got.status, got.angle_deg);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      results_seen++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
      if (got.angle_deg !== want.angle_deg) begin
        $display("%0t: angle_deg mismatch: expected %0d actual %0d",
                 $time, want.angle_deg, got.angle_deg);
        mismatches++;
      end
      if (want.status <= cca_pkg::STAT_VALUE) begin
        status_seen[want.status]++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  cca_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cca_pkg::out_t out_data;

  angle_checker sb;
  int send_idle_pct;
  int recv_stall_pct;
  int holds_asked;
  int holds_started;
  int hold_left;
  int quiet_cycles;

  crc_checked_angle_from_xy #(
    .CORDIC_STAGES  (STAGES),
    .ANGLE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, or a counted hold-off when one is asked for
  always @(negedge clk) begin
    if (holds_started != holds_asked) begin
      holds_started <= holds_asked;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input cca_pkg::in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_xy(input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic [7:0] crc_flip);
    cca_pkg::in_t req;
    req.x_raw     = x;
    req.y_raw     = y;
    req.frame_crc = angle_checker::sensor_crc(x, y) ^ crc_flip;
    send_request(req);
  endtask

  function automatic logic signed [15:0] random_component();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      6:       v = 16'($urandom_range(0, 64)) - 16'sd32;
      7:       v = 16'sd32767 - 16'($urandom_range(0, 2));
      8:       v = -16'sd32768 + 16'($urandom_range(0, 2));
      9:       v = 16'($urandom_range(0, 2)) - 16'sd1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_frames(input int count);
    logic [7:0] flip;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1:    flip = 8'h01 << $urandom_range(0, 7);
        2:       flip = 8'($urandom);
        default: flip = 8'h00;
      endcase
      send_xy(random_component(), random_component(), flip);
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_asked    = 0;
    holds_started  = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one frame per quadrant and near each axis
    send_xy(16'sd1, 16'sd1, 8'h00);
    send_xy(-16'sd1, 16'sd1, 8'h00);
    send_xy(-16'sd1, -16'sd1, 8'h00);
    send_xy(16'sd1, -16'sd1, 8'h00);
    send_xy(16'sd32766, 16'sd1, 8'h00);
    send_xy(-16'sd32767, 16'sd1, 8'h00);
    send_xy(-16'sd32767, -16'sd1, 8'h00);
    send_xy(16'sd1, 16'sd32766, 8'h00);
    send_xy(16'sd1, -16'sd32767, 8'h00);
    send_xy(-16'sd32767, -16'sd32767, 8'h00);
    send_xy(16'sh1234, -16'sh4321, 8'h00);
    // zero or railed values with a good CRC
    send_xy(16'sd0, 16'sd100, 8'h00);
    send_xy(16'sd100, 16'sd0, 8'h00);
    send_xy(16'sd32767, 16'sd5, 8'h00);
    send_xy(16'sd5, 16'sd32767, 8'h00);
    send_xy(-16'sd32768, 16'sd5, 8'h00);
    send_xy(16'sd5, -16'sd32768, 8'h00);
    send_xy(16'sd0, 16'sd0, 8'h00);
    send_xy(-16'sd32768, 16'sd32767, 8'h00);
    // CRC mismatch, also on values that would fail the value check
    send_xy(16'sd100, 16'sd200, 8'h01);
    send_xy(16'sd0, 16'sd0, 8'h80);
    send_xy(-16'sd32768, -16'sd32768, 8'hFF);
    send_xy(16'sd300, -16'sd4000, 8'hFF);

    send_random_frames(PHASE_FRAMES);
    send_idle_pct  = 62;
    send_random_frames(PHASE_FRAMES);
    send_idle_pct  = 0;
    recv_stall_pct <= 62;
    send_random_frames(PHASE_FRAMES);
    send_idle_pct  = 38;
    recv_stall_pct <= 38;
    send_random_frames(PHASE_FRAMES);
    // hold the receiver off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    holds_asked    <= holds_asked + 1;
    send_random_frames(PHASE_FRAMES);
    in_valid <= 1'b0;

    while (sb.awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d results for %0d requests: %0d angles, %0d CRC mismatches,",
             sb.results_seen, sb.requests_seen, sb.status_seen[cca_pkg::STAT_OK],
             sb.status_seen[cca_pkg::STAT_CRC]);
    $display("%0d zero or railed values; traffic: no idling, sender idle, receiver %s",
             sb.status_seen[cca_pkg::STAT_VALUE], "stall, both,");
    $display("and a %0d-cycle receiver hold-off.", HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cca_pkg.sv
hdl/cca_stage.sv
hdl/crc_checked_angle_from_xy.sv
hdl/cca_checker.sv
test/tb_crc_checked_angle_from_xy.sv
